FILE: hw/rtl/tsfwc_pkg.sv
// ----------------------------------------------------------------------------
// tsfwc_pkg: time-code frame with weather cipher, shared constants and functions
// Cipher tables, BCD and small-modulo helpers, Feistel round function.
// ----------------------------------------------------------------------------
package tsfwc_pkg;

  localparam int unsigned Rounds     = 16;
  localparam int unsigned FrameWidth = 59;
  localparam int unsigned HalfWidth  = 20;
  localparam int unsigned KeyWidth   = 40;
  localparam logic [23:0] WeatherReset = 24'd6512678;

  localparam logic [5:0] KEY_PICK [0:29] = '{
    6'd9, 6'd5, 6'd25, 6'd35, 6'd37, 6'd7, 6'd30, 6'd24, 6'd26, 6'd36, 6'd16, 6'd34,
    6'd22, 6'd4, 6'd21, 6'd19, 6'd14, 6'd38, 6'd17, 6'd20, 6'd15, 6'd6, 6'd12, 6'd10,
    6'd0, 6'd31, 6'd3, 6'd1, 6'd18, 6'd28
  };
  localparam logic [4:0] EXPAND_PICK [0:9] = '{
    5'd19, 5'd4, 5'd3, 5'd8, 5'd7, 5'd12, 5'd11, 5'd16, 5'd15, 5'd0
  };
  localparam logic [4:0] PERM_PICK [0:19] = '{
    5'd2, 5'd13, 5'd15, 5'd22, 5'd8, 5'd20, 5'd10, 5'd23, 5'd18, 5'd17,
    5'd3, 5'd9, 5'd14, 5'd1, 5'd12, 5'd19, 5'd11, 5'd21, 5'd16, 5'd0
  };

  localparam logic [7:0] SUB_A [0:63] = '{
    8'hBB, 8'h0E, 8'h22, 8'hC5, 8'h73, 8'hDF, 8'hF7, 8'h6D,
    8'h90, 8'hE9, 8'hA1, 8'h38, 8'h1C, 8'h84, 8'h4A, 8'h56,
    8'h64, 8'h8D, 8'h28, 8'h0B, 8'hD1, 8'hBA, 8'h93, 8'h52,
    8'h1C, 8'hC5, 8'hA7, 8'hF0, 8'hE9, 8'h7F, 8'h36, 8'h4E,
    8'hC1, 8'h77, 8'h3D, 8'hB3, 8'hAA, 8'hE0, 8'h0C, 8'h6F,
    8'h14, 8'h88, 8'hF6, 8'h2B, 8'hD2, 8'h99, 8'h5E, 8'h45,
    8'h1F, 8'h70, 8'h96, 8'hD3, 8'hB3, 8'h0B, 8'hFC, 8'hEE,
    8'h81, 8'h42, 8'hCA, 8'h34, 8'hA5, 8'h58, 8'h29, 8'h67
  };
  localparam logic [7:0] SUB_B [0:63] = '{
    8'hAB, 8'h3D, 8'hFC, 8'h74, 8'h65, 8'hE6, 8'h0E, 8'h4F,
    8'h97, 8'h11, 8'hD8, 8'h59, 8'h83, 8'hC2, 8'hBA, 8'h20,
    8'hC5, 8'h1B, 8'hD2, 8'h58, 8'h49, 8'h37, 8'h01, 8'h7D,
    8'h93, 8'hFA, 8'hE0, 8'h2F, 8'h66, 8'hB4, 8'hAC, 8'h8E,
    8'hB7, 8'hCC, 8'h43, 8'hFF, 8'h58, 8'h66, 8'hEB, 8'h35,
    8'h82, 8'h2A, 8'h99, 8'hDD, 8'h00, 8'h71, 8'h14, 8'hAE,
    8'h4E, 8'hB1, 8'hF7, 8'h70, 8'h18, 8'h52, 8'hAA, 8'h9F,
    8'hD5, 8'h6B, 8'hCC, 8'h3D, 8'h04, 8'h83, 8'hE9, 8'h26
  };
  localparam logic [7:0] SUB_C [0:63] = '{
    8'h0A, 8'h02, 8'h00, 8'h0F, 8'h06, 8'h07, 8'h0D, 8'h08,
    8'h03, 8'h0C, 8'h0B, 8'h05, 8'h09, 8'h01, 8'h04, 8'h0E,
    8'h02, 8'h09, 8'h05, 8'h0D, 8'h0C, 8'h0E, 8'h0F, 8'h08,
    8'h06, 8'h07, 8'h0B, 8'h01, 8'h00, 8'h0A, 8'h04, 8'h03,
    8'h08, 8'h00, 8'h0D, 8'h0F, 8'h01, 8'h0C, 8'h03, 8'h06,
    8'h0B, 8'h04, 8'h09, 8'h05, 8'h0A, 8'h07, 8'h02, 8'h0E,
    8'h03, 8'h0D, 8'h00, 8'h0C, 8'h09, 8'h06, 8'h0F, 8'h0B,
    8'h01, 8'h0E, 8'h08, 8'h0A, 8'h02, 8'h07, 8'h04, 8'h05
  };

  function automatic logic [7:0] bcd8(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  units;
    prod  = 16'(v) * 16'd205;
    tens  = prod[15:11];
    units = v - (8'(tens) * 8'd10);
    return {tens[3:0], units[3:0]};
  endfunction

  function automatic logic [1:0] mod3(input logic [5:0] v);
    logic [12:0] prod;
    logic [5:0]  q;
    logic [5:0]  r;
    prod = 13'(v) * 13'd43;
    q    = 6'(prod >> 7);
    r    = v - 6'(q * 6'd3);
    return r[1:0];
  endfunction

  function automatic logic [6:0] mod100(input logic [7:0] v);
    logic [15:0] prod;
    logic [7:0]  r;
    prod = 16'(v) * 16'd41;
    r    = v - 8'(prod[13:12] * 8'd100);
    return r[6:0];
  endfunction

  function automatic logic [KeyWidth-1:0] key_rot(input logic [KeyWidth-1:0] k);
    logic [7:0]  hi;
    logic [31:0] lo;
    logic        t;
    hi = k[39:32];
    lo = k[31:0];
    t  = hi[7];
    hi = {hi[6:0], lo[31]};
    lo = {lo[30:0], 1'b0};
    if (lo[20]) begin
      lo[0] = 1'b1;
    end
    lo[20] = t;
    return {hi, lo};
  endfunction

  function automatic logic [23:0] sbox_f(input logic [29:0] ain);
    logic [31:0] a;
    logic [31:0] f;
    logic [7:0]  h;
    logic [7:0]  t;
    logic [7:0]  b;
    a = {2'b00, ain};
    f = '0;
    h = a[31:24];
    a[31:24] = a[23:16];
    for (int i = 5; i > 0; i--) begin
      if ((i % 2) == 0) begin
        a[7:0] = {a[3:0], a[7:4]};
      end
      a[27:24] = 4'h0;
      t = {a[31:28], a[3:0]};
      case (i)
        5, 4:    t = SUB_A[t[5:0]];
        3, 2:    t = SUB_B[t[5:0]];
        default: t = SUB_C[t[5:0]];
      endcase
      if ((i % 2) == 1) begin
        f[7:0] = {4'h0, t[3:0]};
      end else begin
        f[7:0] = f[7:0] | {t[7:4], 4'h0};
        b = a[31:24];
        a = {b, a[31:8]};
        f = f << 8;
      end
      for (int r = 0; r < 2; r++) begin
        a[31:24] = {h[0], a[31:25]};
        h = h >> 1;
      end
    end
    return f[23:0];
  endfunction

  function automatic logic [HalfWidth-1:0] round_f(input logic [HalfWidth-1:0] left,
                                                   input logic [KeyWidth-1:0] key);
    logic [29:0] ex;
    logic [29:0] kc;
    logic [23:0] f;
    logic [19:0] p;
    ex = {10'b0, left};
    for (int n = 0; n < 10; n++) begin
      ex[20+n] = left[EXPAND_PICK[n]];
    end
    for (int n = 0; n < 30; n++) begin
      kc[n] = key[KEY_PICK[n]];
    end
    f = sbox_f(kc ^ ex);
    for (int n = 0; n < 20; n++) begin
      p[n] = f[PERM_PICK[n]];
    end
    return p;
  endfunction

endpackage

FILE: hw/rtl/time_signal_frame_with_weather_cipher_core.sv
// ----------------------------------------------------------------------------
// time_signal_frame_with_weather_cipher_core
// Builds the 59-bit time-code frame of one minute with an encrypted weather slice.
//
//  channel   dir  fields (lsb first)
//  s_axis    in   minute 6, hour 5, day 5, weekday 3, month 4, year 8, summer 1
//  m_axis    out  frame_bits 59
//  weather   in   weather_data 24, written when weather_data_we is high
//
// 18 register stages: one setup stage (BCD, key, parity), one stage per cipher
// round, one output stage. One item per cycle sustained while m_axis_tready
// stays high.
// Each stage advances when empty or when the next one advances; bubbles collapse.
// rst clears all valid bits and loads weather_reg with its default word.
// ----------------------------------------------------------------------------
module time_signal_frame_with_weather_cipher_core
  import tsfwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        weather_data_we,
  input  logic [23:0] weather_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // minute[5:0] hour[10:6] day[15:11] weekday[18:16] month[22:19] year[30:23] summer[31]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // frame_bits[58:0], zero padding above
  output logic [63:0] m_axis_tdata
);

  localparam int unsigned Last = Rounds + 1;

  logic [23:0] weather_reg;

  logic              vld   [0:Last];
  logic              rdy   [0:Last];
  logic [19:0]       left  [0:Rounds];
  logic [19:0]       right [0:Rounds];
  logic [KeyWidth-1:0] key [0:Rounds];
  logic [FrameWidth-1:0] base [0:Rounds];
  logic [1:0]        sec   [0:Rounds];
  logic [FrameWidth-1:0] frame;

  logic [5:0] mi;
  logic [4:0] hr, dy;
  logic [2:0] wd, dow;
  logic [3:0] mo;
  logic [7:0] yr;
  logic       st;
  logic [1:0] sec_in;
  logic [7:0] dow_bcd;
  logic [7:0] mon_key_bcd;
  logic [KeyWidth-1:0] key_in;
  logic [63:0] fb;
  logic [39:0] cipher;
  logic [41:0] spread;
  logic [13:0] slice;

  always_ff @(posedge clk) begin
    if (rst) begin
      weather_reg <= WeatherReset;
    end else if (weather_data_we) begin
      weather_reg <= weather_data;
    end
  end

  always_comb begin
    rdy[Last] = !vld[Last] || m_axis_tready;
    for (int k = Last - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];

  always_comb begin
    mi  = s_axis_tdata[5:0];
    hr  = s_axis_tdata[10:6];
    dy  = s_axis_tdata[15:11];
    wd  = s_axis_tdata[18:16];
    mo  = s_axis_tdata[22:19];
    yr  = s_axis_tdata[30:23];
    st  = s_axis_tdata[31];
    dow = (wd == 3'd0) ? 3'd7 : wd;
    sec_in = mod3(mi);
    dow_bcd = bcd8({5'b0, dow});
    mon_key_bcd = bcd8({4'b0, mo} - 8'd1);
    key_in = {bcd8(yr), dow_bcd[2:0], mon_key_bcd[4:0],
              bcd8({3'b0, dy}), bcd8({3'b0, hr}),
              bcd8(8'({2'b0, mi}) + 8'd2 - 8'({6'b0, sec_in}))};
    fb = '0;
    fb[17] = st;
    fb[18] = !st;
    fb[20] = 1'b1;
    fb = fb | (64'(bcd8({2'b0, mi})) << 21);
    fb = fb | (64'(bcd8({3'b0, hr})) << 29);
    fb = fb | (64'(bcd8({3'b0, dy})) << 36);
    fb = fb | (64'(dow_bcd) << 42);
    fb = fb | (64'(bcd8({4'b0, mo})) << 45);
    fb = fb | (64'(bcd8({1'b0, mod100(yr)})) << 50);
    fb[28] = fb[28] | (^fb[27:21]);
    fb[35] = fb[35] | (^fb[34:29]);
    fb[58] = fb[58] | (^fb[57:36]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      left[0]  <= {4'h2, 8'h50, 4'h1, weather_reg[23:20]};
      right[0] <= weather_reg[19:0];
      key[0]   <= key_in;
      base[0]  <= fb[FrameWidth-1:0];
      sec[0]   <= sec_in;
    end
  end

  for (genvar k = 1; k <= Rounds; k++) begin : g_round
    logic [KeyWidth-1:0] key_once;
    logic [KeyWidth-1:0] key_next;

    always_comb begin
      key_once = key_rot(key[k-1]);
      if (k == 3 || k == 7 || k == 8 || k == 16) begin
        key_next = key_rot(key_once);
      end else begin
        key_next = key_once;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        left[k]  <= round_f(left[k-1], key[k-1]) ^ right[k-1];
        right[k] <= left[k-1];
        key[k]   <= key_next;
        base[k]  <= base[k-1];
        sec[k]   <= sec[k-1];
      end
    end
  end

  always_comb begin
    cipher = {right[Rounds], left[Rounds]};
    spread = {cipher[39:6], 1'b0, cipher[5:0], 1'b0};
    case (sec[Rounds])
      2'd0:    slice = spread[13:0];
      2'd1:    slice = spread[27:14];
      2'd2:    slice = spread[41:28];
      default: slice = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[Last] <= 1'b0;
    end else if (rdy[Last]) begin
      vld[Last] <= vld[Rounds];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[Last]) begin
      frame <= base[Rounds] | {44'b0, slice, 1'b0};
    end
  end

  assign m_axis_tvalid = vld[Last];
  assign m_axis_tdata  = {5'b0, frame};

  a_start_bit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[20])
    else $error("start bit missing");

  a_dst_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[17] != m_axis_tdata[18]))
    else $error("summer/winter flags not complementary");

  a_zero_bits: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[0] == 1'b0 && m_axis_tdata[15] == 1'b0 &&
                       m_axis_tdata[16] == 1'b0 && m_axis_tdata[19] == 1'b0))
    else $error("reserved frame bits set");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted item lost at entry stage");

endmodule

FILE: tb/tb_time_signal_frame_with_weather_cipher_core.sv
// ----------------------------------------------------------------------------
// Time-code frame generator with weather cipher: self-checking testbench
// Streams broken-down minutes into the core, predicts each 59-bit frame
// (BCD fields, parity, summer flags and the encrypted weather slice) with a
// local cipher model, and compares every output item in order. Covers field
// extremes, out-of-range codes, several weather words and random back-pressure.
// ----------------------------------------------------------------------------
module tb_time_signal_frame_with_weather_cipher_core;
  import tsfwc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 270;
  localparam int unsigned DrainCycles = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        weather_data_we = 1'b0;
  logic [23:0] weather_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  logic [31:0] minutes_to_send [$];
  logic [58:0] frames_due [$];
  logic [23:0] weather_word = WeatherReset;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  time_signal_frame_with_weather_cipher_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .weather_data_we(weather_data_we),
    .weather_data   (weather_data),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] to_bcd(input logic [31:0] v);
    return 8'((((v / 10) << 4) | (v % 10)) & 32'hFF);
  endfunction

  function automatic logic [31:0] sbox_mix(input logic [31:0] ain, input logic [31:0] fin,
                                           output logic [31:0] fout);
    logic [31:0] a;
    logic [31:0] f;
    logic [7:0]  h;
    logic [7:0]  t;
    logic [7:0]  b;
    a = ain;
    f = fin;
    h = a[31:24];
    a[31:24] = a[23:16];
    for (int i = 5; i > 0; i--) begin
      if (i % 2 == 0) begin
        a[7:0] = {a[3:0], a[7:4]};
      end
      a[31:24] = a[31:24] & 8'hF0;
      t = {4'h0, a[3:0]} | a[31:24];
      if (i >= 4) begin
        t = SUB_A[t[5:0]];
      end else if (i >= 2) begin
        t = SUB_B[t[5:0]];
      end else begin
        t = SUB_C[t[5:0]];
      end
      if (i % 2 == 1) begin
        f[7:0] = {4'h0, t[3:0]};
      end else begin
        f[7:0] = f[7:0] | {t[7:4], 4'h0};
        b = a[31:24];
        a = a >> 8;
        a[31:24] = b;
        f = f << 8;
      end
      for (int r = 0; r < 2; r++) begin
        a[31:24] = {h[0], a[31:25]};
        h = h >> 1;
      end
    end
    fout = f;
    return a;
  endfunction

  function automatic logic [39:0] weather_cipher(input logic [23:0] w, input logic [39:0] key);
    logic [31:0] lo;
    logic [7:0]  hi;
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] a;
    logic [31:0] f;
    logic [31:0] p2;
    logic [39:0] tk;
    logic        t;
    int          turns;
    lo = key[31:0];
    hi = key[39:32];
    p2 = {24'h0, w[3:0], 4'h2};
    left = {12'h0, p2[3:0], 8'h50, 4'h1, w[23:20]} & 32'h000FFFFF;
    right = (p2 | {16'h0, w[11:4], 8'h0} | {8'h0, w[19:12], 16'h0}) >> 4;
    f = '0;
    for (int rnd = 1; rnd <= 16; rnd++) begin
      left = left & 32'h000FFFFF;
      for (int n = 0; n < 10; n++) begin
        if (left[EXPAND_PICK[n]]) begin
          left[20+n] = 1'b1;
        end
      end
      tk = {hi, lo};
      a = '0;
      for (int n = 0; n < 30; n++) begin
        a[n] = tk[KEY_PICK[n]];
      end
      a = a ^ left;
      right = right & ~32'h00F00000;
      a = sbox_mix(a, f, f);
      a = 32'hFF000000;
      for (int n = 0; n < 20; n++) begin
        if (f[PERM_PICK[n]]) begin
          a[n] = 1'b1;
        end
      end
      a = a ^ right;
      right = left & 32'h00FFFFFF;
      left = a & 32'h00FFFFFF;
      turns = (rnd == 16 || rnd == 8 || rnd == 7 || rnd == 3) ? 2 : 1;
      for (int k = 0; k < turns; k++) begin
        t = hi[7];
        hi = {hi[6:0], lo[31]};
        lo = lo << 1;
        if (lo[20]) begin
          lo[0] = 1'b1;
        end
        lo[20] = t;
      end
    end
    right = right << 4;
    left[23:16] = {right[7:4], left[19:16]};
    return {right[23:16], right[15:8], left[23:0]};
  endfunction

  function automatic logic [58:0] predict_frame(input logic [31:0] d, input logic [23:0] w);
    logic [31:0] mi;
    logic [31:0] sec;
    logic [31:0] dow;
    logic [7:0]  dow_bcd;
    logic [7:0]  mon_key_bcd;
    logic [7:0]  mon_bcd;
    logic [39:0] key;
    logic [39:0] c;
    logic [63:0] s;
    logic [63:0] fb;
    mi = 32'(d[5:0]);
    sec = mi % 3;
    dow = (d[18:16] == 3'd0) ? 32'd7 : 32'(d[18:16]);
    dow_bcd = to_bcd(dow);
    mon_key_bcd = to_bcd((32'(d[22:19]) - 1) & 32'hFF);
    mon_bcd = to_bcd(32'(d[22:19]));
    key = {to_bcd(32'(d[30:23])), dow_bcd[2:0], mon_key_bcd[4:0],
           to_bcd(32'(d[15:11])), to_bcd(32'(d[10:6])), to_bcd(mi + 2 - sec)};
    c = weather_cipher(w, key);
    s = (64'(c[5:0]) << 1) | (64'(c[39:6]) << 8);
    fb = ((s >> (14 * sec)) & 64'h3FFF) << 1;
    fb[17] = d[31];
    fb[18] = ~d[31];
    fb[20] = 1'b1;
    fb[28:21] = to_bcd(mi);
    fb[36:29] = to_bcd(32'(d[10:6]));
    fb[44:36] = fb[44:36] | 9'(to_bcd(32'(d[15:11])));
    fb[44:42] = fb[44:42] | dow_bcd[2:0];
    fb[49:45] = mon_bcd[4:0];
    fb[57:50] = to_bcd(32'(d[30:23]) % 100);
    fb[28] = ^fb[27:21];
    fb[35] = ^fb[34:29];
    fb[58] = ^fb[57:36];
    return fb[58:0];
  endfunction

  function automatic logic [31:0] pack_minute(input int mi, input int hr, input int dy,
                                              input int wd, input int mo, input int yr,
                                              input int st);
    return {1'(st), 8'(yr), 4'(mo), 3'(wd), 5'(dy), 5'(hr), 6'(mi)};
  endfunction

  function automatic logic [31:0] random_minute();
    if ($urandom_range(99) < 80) begin
      return pack_minute($urandom_range(59), $urandom_range(23), $urandom_range(31, 1),
                         $urandom_range(6), $urandom_range(12, 1), $urandom_range(199),
                         $urandom_range(1));
    end
    return $urandom;
  endfunction

  // driver: predict on acceptance, then advance to the next item or idle
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        frames_due.push_back(predict_frame(s_axis_tdata, weather_word));
      end
      if (minutes_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        s_axis_tdata <= minutes_to_send.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (frames_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) begin
          $display("unexpected frame %h", m_axis_tdata[58:0]);
        end
      end else begin
        if (m_axis_tdata[58:0] !== frames_due[0] || m_axis_tdata[63:59] !== 5'd0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("frame mismatch: expected %h actual %h", frames_due[0],
                     m_axis_tdata);
          end
        end
        void'(frames_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic wait_drained();
    while (minutes_to_send.size() > 0 || s_axis_tvalid || frames_due.size() > 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_weather(input logic [23:0] v);
    @(posedge clk);
    weather_data_we <= 1'b1;
    weather_data <= v;
    weather_word <= v;
    @(posedge clk);
    weather_data_we <= 1'b0;
  endtask

  initial begin
    logic [23:0] words [6];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, out-of-range codes, each slice
    minutes_to_send.push_back(pack_minute(0, 0, 1, 0, 1, 0, 0));
    minutes_to_send.push_back(pack_minute(59, 23, 31, 6, 12, 199, 1));
    minutes_to_send.push_back(pack_minute(63, 31, 31, 7, 15, 255, 1));
    minutes_to_send.push_back(pack_minute(0, 0, 0, 0, 0, 0, 0));
    minutes_to_send.push_back(pack_minute(1, 12, 15, 3, 6, 100, 0));
    minutes_to_send.push_back(pack_minute(2, 12, 15, 3, 6, 100, 1));
    minutes_to_send.push_back(pack_minute(57, 5, 9, 7, 10, 99, 0));
    minutes_to_send.push_back(pack_minute(58, 5, 9, 0, 10, 101, 0));
    minutes_to_send.push_back(pack_minute(30, 9, 20, 1, 2, 126, 1));
    minutes_to_send.push_back(pack_minute(61, 24, 0, 5, 13, 200, 1));
    minutes_to_send.push_back(32'hFFFFFFFF);
    minutes_to_send.push_back(32'h0);
    minutes_to_send.push_back(32'hAAAAAAAA);
    minutes_to_send.push_back(32'h55555555);
    wait_drained();
    words[0] = 24'h000000;
    words[1] = 24'hFFFFFF;
    words[2] = 24'(WeatherReset);
    words[3] = 24'($urandom);
    words[4] = 24'($urandom);
    words[5] = 24'($urandom);
    for (int ph = 0; ph < 6; ph++) begin
      load_weather(words[ph]);
      send_gap_pct <= (ph < 2) ? 36 : (ph < 4) ? 75 : 0;
      recv_gap_pct <= (ph < 2) ? 75 : (ph < 4) ? 36 : 0;
      for (int n = 0; n < PhaseItems; n++) begin
        minutes_to_send.push_back(random_minute());
      end
      if (ph == 4) begin
        hold_req <= hold_req + 1;
      end
      if (ph == 2) begin
        while (minutes_to_send.size() > PhaseItems / 2) begin
          @(posedge clk);
        end
        wait_drained();
        for (int n = 0; n < 20; n++) begin
          minutes_to_send.push_back(random_minute());
        end
      end
      wait_drained();
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: time_signal_frame_with_weather_cipher_core.f
hw/rtl/tsfwc_pkg.sv
hw/rtl/time_signal_frame_with_weather_cipher_core.sv
tb/tb_time_signal_frame_with_weather_cipher_core.sv
